[sv/u8sv_pkg.sv]
// Shared types and constants for the UTF-8 stream validator.
package u8sv_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

  // Lead and continuation byte masks with their match patterns.
  localparam logic [7:0] MASK_ASCII = 8'b1000_0000;
  localparam logic [7:0] MASK_CONT  = 8'b1100_0000;
  localparam logic [7:0] MASK_LEAD2 = 8'b1110_0000;
  localparam logic [7:0] MASK_LEAD3 = 8'b1111_0000;
  localparam logic [7:0] MASK_LEAD4 = 8'b1111_1000;

  localparam logic [7:0] PAT_ASCII = 8'b0000_0000;
  localparam logic [7:0] PAT_CONT  = 8'b1000_0000;
  localparam logic [7:0] PAT_LEAD2 = 8'b1100_0000;
  localparam logic [7:0] PAT_LEAD3 = 8'b1110_0000;
  localparam logic [7:0] PAT_LEAD4 = 8'b1111_0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

endpackage

[sv/utf8_stream_validator.sv]
// Top level of the UTF-8 stream validator.
//
// The input channel (in_valid, in_ready, in_data_byte, in_last_byte) carries
// one message byte per transaction; in_last_byte marks the final byte of a
// message. The result channel (out_valid, out_ready, out_is_valid,
// out_code_point_count) carries one transaction per message, issued for
// its last byte. out_code_point_count saturates at 65535 and reads zero
// when the message breaks the UTF-8 lead/continuation byte structure.
//
// A byte is taken every cycle while in_ready is high. It is checked while it
// sits in the input register; out_valid rises once the checker takes its last
// byte into the result register. Throughput is one byte per cycle; the only
// limit is the single result register, which must be free or draining before
// the next last byte can pass the checker.
//
// While out_ready is low, bytes that are not the end of a message keep
// flowing; a last byte waits in the input register while a result is held
// and in_ready drops once it is full. Synchronous reset (rst_n low) empties
// both registers and clears the pending count, error flag and counter.
module utf8_stream_validator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_valid,
  output logic [u8sv_pkg::CountW-1:0]  out_code_point_count
);

  u8sv_pkg::byte_item_t in_item;
  u8sv_pkg::byte_item_t hold_item;
  logic                 hold_valid;
  logic                 hold_take;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  u8sv_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_item  (hold_item)
  );

  u8sv_check u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .hold_valid           (hold_valid),
    .hold_take            (hold_take),
    .hold_item            (hold_item),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_valid         (out_is_valid),
    .out_code_point_count (out_code_point_count)
  );

endmodule

[sv/u8sv_in_reg.sv]
// Input register stage that holds one byte transaction for the checker.
module u8sv_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u8sv_pkg::byte_item_t  in_item,
  output logic                  hold_valid,
  input  logic                  hold_take,
  output u8sv_pkg::byte_item_t  hold_item
);

  logic                 valid_r;
  u8sv_pkg::byte_item_t item_r;

  // The stage refills in the same cycle that the checker takes its byte.
  assign in_ready   = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[sv/u8sv_check.sv]
// Sequence checker: pending count, sticky error, code-point counter and result register.
module u8sv_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           hold_valid,
  output logic                           hold_take,
  input  u8sv_pkg::byte_item_t           hold_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_valid,
  output logic [u8sv_pkg::CountW-1:0]    out_code_point_count
);

  logic [1:0]                    pend_r, pend_nxt;
  logic                          err_r, err_nxt;
  logic [u8sv_pkg::CountW-1:0]   cnt_r, cnt_nxt;
  logic                          res_valid_r;
  logic                          res_ok_r, res_ok_nxt;
  logic [u8sv_pkg::CountW-1:0]   res_cnt_r;
  logic                          counted;
  logic [7:0]                    b;

  assign b = hold_item.data_byte;

  // A last byte can only move on when the result register is free or draining.
  assign hold_take = hold_valid &&
                     (!hold_item.last_byte || !res_valid_r || out_ready);

  always_comb begin
    pend_nxt = pend_r;
    err_nxt  = err_r;
    counted  = 1'b0;
    if (pend_r != 2'd0) begin
      if ((b & u8sv_pkg::MASK_CONT) != u8sv_pkg::PAT_CONT) begin
        err_nxt = 1'b1;
      end
      pend_nxt = pend_r - 2'd1;
    end else if ((b & u8sv_pkg::MASK_ASCII) == u8sv_pkg::PAT_ASCII) begin
      counted = 1'b1;
    end else if ((b & u8sv_pkg::MASK_LEAD2) == u8sv_pkg::PAT_LEAD2) begin
      counted  = 1'b1;
      pend_nxt = 2'd1;
    end else if ((b & u8sv_pkg::MASK_LEAD3) == u8sv_pkg::PAT_LEAD3) begin
      counted  = 1'b1;
      pend_nxt = 2'd2;
    end else if ((b & u8sv_pkg::MASK_LEAD4) == u8sv_pkg::PAT_LEAD4) begin
      counted  = 1'b1;
      pend_nxt = 2'd3;
    end else begin
      err_nxt = 1'b1;
    end
    cnt_nxt = cnt_r;
    if (counted && (cnt_r < u8sv_pkg::COUNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    res_ok_nxt = !err_nxt && (pend_nxt == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 2'd0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (hold_take && hold_item.last_byte) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
      if (hold_take) begin
        if (hold_item.last_byte) begin
          // End of message: publish the result and start the next one clean.
          pend_r <= 2'd0;
          err_r  <= 1'b0;
          cnt_r  <= '0;
        end else begin
          pend_r <= pend_nxt;
          err_r  <= err_nxt;
          cnt_r  <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_take && hold_item.last_byte) begin
      res_ok_r  <= res_ok_nxt;
      res_cnt_r <= res_ok_nxt ? cnt_nxt : '0;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_is_valid         = res_ok_r;
  assign out_code_point_count = res_cnt_r;

endmodule
